@@ rtl/selective_repeat_arq_controller_unit_defines.svh @@
// Assertion macros used by the selective repeat ARQ controller top level.
`ifndef SELECTIVE_REPEAT_ARQ_CONTROLLER_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SRAQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SRAQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRAQ_ASSERT_IMP(label, ante, cons, msg)
`define SRAQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/sraq_pkg.sv @@
// Package with codes and defaults of the selective repeat ARQ controller.
package sraq_pkg;
    localparam int WINDOW_COUNT_DEF = 32;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam logic [15:0] DATA_TIMEOUT_RST = 16'd3100;
    localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd1150;

    localparam logic [2:0] CMD_NEW_PACKET   = 3'd0;
    localparam logic [2:0] CMD_LINK_READY   = 3'd1;
    localparam logic [2:0] CMD_FRAME        = 3'd2;
    localparam logic [2:0] CMD_DATA_TIMEOUT = 3'd3;
    localparam logic [2:0] CMD_ACK_TIMEOUT  = 3'd4;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;

    localparam logic [2:0] ACT_SEND_DATA = 3'd0;
    localparam logic [2:0] ACT_SEND_ACK  = 3'd1;
    localparam logic [2:0] ACT_SEND_NAK  = 3'd2;
    localparam logic [2:0] ACT_DELIVER   = 3'd3;
    localparam logic [2:0] ACT_STOP_TMR  = 3'd4;
    localparam logic [2:0] ACT_ACK_TMR   = 3'd5;
    localparam logic [2:0] ACT_STATUS    = 3'd6;

    localparam logic CFG_DATA_TIMEOUT = 1'b0;
    localparam logic CFG_ACK_TIMEOUT  = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DISP  = 11'b000_0000_0010,
        S_NAK   = 11'b000_0000_0100,
        S_SEND  = 11'b000_0000_1000,
        S_STORE = 11'b000_0001_0000,
        S_DLVRD = 11'b000_0010_0000,
        S_DLV   = 11'b000_0100_0000,
        S_ATMR  = 11'b000_1000_0000,
        S_CACK  = 11'b001_0000_0000,
        S_CWALK = 11'b010_0000_0000,
        S_STAT  = 11'b100_0000_0000
    } t_state;
endpackage

@@ rtl/selective_repeat_arq_controller_unit.sv @@
// Top level of the selective repeat ARQ controller.
//
// One event enters on the input channel (valid/ready) and leaves a list of
// actions on the output channel, one beat per action; the status beat, with
// o_last high, closes every event. The input is taken only between events.
// An event passes the idle and decode states, then: for a new packet or a
// link ready, status; for a data timeout retransmission, send and status;
// for a NAK retransmission, send, acknowledge check, a walk step per freed
// send slot and status; for an in-order data frame, store, one delivery
// check and step per delivery, a last check, acknowledge timer, acknowledge
// check, walk steps and status. The delivery and acknowledge walks set the
// length of long events; each payload memory has one registered read port.
// Reset clears the window pointers, counters, receive valid and acknowledge
// bits and loads the timeout registers with their defaults; the payload
// memories are not cleared. A stalled output holds a beat-emitting state
// until the pending beat is taken. Write i_cfg_* only between events.
module selective_repeat_arq_controller_unit #(
    parameter int WINDOW_COUNT = sraq_pkg::WINDOW_COUNT_DEF,
    parameter int PAYLOAD_BITS = sraq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [63:0] i_payload,
    input  logic [1:0]  i_frame_kind,
    input  logic [4:0]  i_frame_seq,
    input  logic [4:0]  i_frame_ack,
    input  logic        i_frame_good,
    input  logic [4:0]  i_timeout_seq,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_action,
    output logic [4:0]  o_out_seq,
    output logic [4:0]  o_out_ack,
    output logic [63:0] o_out_payload,
    output logic [15:0] o_timer_value,
    output logic        o_network_enable,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
`include "selective_repeat_arq_controller_unit_defines.svh"

    localparam int SW   = $clog2(WINDOW_COUNT);
    localparam int VW   = ((SW > 5) ? SW : 5) + 1;
    localparam int HALF = WINDOW_COUNT / 2;
    localparam int CW   = $clog2(HALF + 1);
    localparam logic [VW-1:0] W_V   = VW'(WINDOW_COUNT);
    localparam logic [SW-1:0] W_MAX = SW'(WINDOW_COUNT - 1);
    localparam logic [SW-1:0] HALF_S = SW'(HALF);
    localparam logic [CW-1:0] HALF_C = CW'(HALF);

    function automatic logic [SW-1:0] wrap_in(input logic [4:0] v);
        logic [VW-1:0] t;
        t = VW'(v);
        for (int k = 0; k < 8; k++) begin
            if (t >= W_V) t = t - W_V;
        end
        return t[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] add_mod(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [VW-1:0] s;
        s = VW'(a) + VW'(b);
        if (s >= W_V) s = s - W_V;
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] sub_mod(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [VW-1:0] s;
        s = VW'(a) + W_V - VW'(b);
        if (s >= W_V) s = s - W_V;
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] inc_mod(input logic [SW-1:0] a);
        return (a == W_MAX) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [SW-1:0] dec_mod(input logic [SW-1:0] a);
        return (a == '0) ? W_MAX : a - 1'b1;
    endfunction

    function automatic logic in_range(input logic [SW-1:0] lo, input logic [SW-1:0] pos,
                                      input logic [SW-1:0] hi);
        return sub_mod(pos, lo) < sub_mod(hi, lo);
    endfunction

    function automatic logic [4:0] seq5(input logic [SW-1:0] s);
        logic [VW-1:0] t;
        t = VW'(s);
        return t[4:0];
    endfunction

    function automatic logic [63:0] pay64(input logic [PAYLOAD_BITS-1:0] p);
        logic [63:0] t;
        t = '0;
        t[PAYLOAD_BITS-1:0] = p;
        return t;
    endfunction

    logic [PAYLOAD_BITS-1:0] send_mem [WINDOW_COUNT];
    logic [PAYLOAD_BITS-1:0] recv_mem [WINDOW_COUNT];

    sraq_pkg::t_state r_state, n_state;
    logic [2:0]              r_cmd;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [1:0]              r_kind;
    logic [SW-1:0]           r_seq, r_ack, n_ack, r_tseq, r_tx_seq, n_tx_seq;
    logic                    r_good;
    logic [SW-1:0]           r_low, n_low, r_high, n_high, r_exp, n_exp;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_link, n_link, r_nak, n_nak;
    logic [WINDOW_COUNT-1:0] r_rvalid, n_rvalid, r_adone, n_adone;
    logic [15:0]             r_data_to, r_ack_to;
    logic [PAYLOAD_BITS-1:0] r_sdata, r_rdata;

    logic        r_ovalid, n_ovalid;
    logic [2:0]  r_action, n_action;
    logic [4:0]  r_oseq, n_oseq, r_oack, n_oack;
    logic [63:0] r_opay, n_opay;
    logic [15:0] r_otmr, n_otmr;
    logic        r_one, n_one, r_olast, n_olast;

    logic          can_emit, send_we, recv_we;
    logic [SW-1:0] send_raddr, last_io;

    assign can_emit   = !r_ovalid || i_out_ready;
    assign last_io    = dec_mod(r_exp);
    assign send_raddr = (r_cmd == sraq_pkg::CMD_DATA_TIMEOUT) ? r_tseq : r_ack;
    assign send_we    = (r_state == sraq_pkg::S_DISP) && (r_cmd == sraq_pkg::CMD_NEW_PACKET)
                        && (r_cnt < HALF_C);
    assign recv_we    = (r_state == sraq_pkg::S_STORE)
                        && in_range(r_exp, r_seq, add_mod(r_exp, HALF_S));

    always_ff @(posedge i_clk) begin
        if (send_we) begin
            send_mem[r_high] <= r_pay;
        end
        if (r_state == sraq_pkg::S_DISP) begin
            r_sdata <= send_mem[send_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (recv_we) begin
            recv_mem[r_seq] <= r_pay;
        end
        r_rdata <= recv_mem[r_exp];
    end

    always_comb begin
        n_state  = r_state;
        n_ack    = r_ack;
        n_tx_seq = r_tx_seq;
        n_low    = r_low;
        n_high   = r_high;
        n_exp    = r_exp;
        n_cnt    = r_cnt;
        n_link   = r_link;
        n_nak    = r_nak;
        n_rvalid = r_rvalid;
        n_adone  = r_adone;
        n_ovalid = r_ovalid && !i_out_ready;
        n_action = r_action;
        n_oseq   = r_oseq;
        n_oack   = r_oack;
        n_opay   = r_opay;
        n_otmr   = r_otmr;
        n_one    = r_one;
        n_olast  = r_olast;
        if (can_emit) begin
            n_oseq  = '0;
            n_oack  = '0;
            n_opay  = '0;
            n_otmr  = '0;
            n_one   = 1'b0;
            n_olast = 1'b0;
        end
        case (r_state)
            sraq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sraq_pkg::S_DISP;
                end
            end
            sraq_pkg::S_DISP: begin
                case (r_cmd)
                    sraq_pkg::CMD_NEW_PACKET: begin
                        if (r_cnt >= HALF_C) begin
                            n_state = sraq_pkg::S_STAT;
                        end else if (can_emit) begin
                            n_ovalid = 1'b1;
                            n_action = sraq_pkg::ACT_SEND_DATA;
                            n_oseq   = seq5(r_high);
                            n_oack   = seq5(last_io);
                            n_opay   = pay64(r_pay);
                            n_otmr   = r_data_to;
                            n_link   = 1'b0;
                            n_cnt    = r_cnt + 1'b1;
                            n_high   = inc_mod(r_high);
                            n_state  = sraq_pkg::S_STAT;
                        end
                    end
                    sraq_pkg::CMD_LINK_READY: begin
                        n_link  = 1'b1;
                        n_state = sraq_pkg::S_STAT;
                    end
                    sraq_pkg::CMD_FRAME: begin
                        if (!r_good) begin
                            n_state = sraq_pkg::S_NAK;
                        end else if (r_kind == sraq_pkg::KIND_NAK) begin
                            n_ack    = dec_mod(r_ack);
                            n_tx_seq = r_ack;
                            n_state  = in_range(r_low, r_ack, r_high) ?
                                       sraq_pkg::S_SEND : sraq_pkg::S_CACK;
                        end else if (r_kind == sraq_pkg::KIND_DATA) begin
                            n_state = (r_seq != r_exp) ? sraq_pkg::S_NAK : sraq_pkg::S_STORE;
                        end else begin
                            n_state = sraq_pkg::S_CACK;
                        end
                    end
                    sraq_pkg::CMD_DATA_TIMEOUT: begin
                        n_tx_seq = r_tseq;
                        n_state  = in_range(r_low, r_tseq, r_high) ?
                                   sraq_pkg::S_SEND : sraq_pkg::S_STAT;
                    end
                    sraq_pkg::CMD_ACK_TIMEOUT: begin
                        if (r_adone[last_io]) begin
                            n_state = sraq_pkg::S_STAT;
                        end else if (can_emit) begin
                            n_ovalid          = 1'b1;
                            n_action          = sraq_pkg::ACT_SEND_ACK;
                            n_oack            = seq5(last_io);
                            n_adone[last_io]  = 1'b1;
                            n_link            = 1'b0;
                            n_state           = sraq_pkg::S_STAT;
                        end
                    end
                    default: begin
                        n_state = sraq_pkg::S_STAT;
                    end
                endcase
            end
            sraq_pkg::S_NAK: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    if (!r_nak) begin
                        n_action = sraq_pkg::ACT_SEND_NAK;
                        n_oack   = seq5(r_exp);
                        n_nak    = 1'b1;
                        n_link   = 1'b0;
                    end else begin
                        n_action = sraq_pkg::ACT_ACK_TMR;
                        n_otmr   = r_ack_to;
                    end
                    n_state = r_good ? sraq_pkg::S_STORE : sraq_pkg::S_STAT;
                end
            end
            sraq_pkg::S_SEND: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_action = sraq_pkg::ACT_SEND_DATA;
                    n_oseq   = seq5(r_tx_seq);
                    n_oack   = seq5(last_io);
                    n_opay   = pay64(r_sdata);
                    n_otmr   = r_data_to;
                    n_link   = 1'b0;
                    n_state  = (r_cmd == sraq_pkg::CMD_DATA_TIMEOUT) ?
                               sraq_pkg::S_STAT : sraq_pkg::S_CACK;
                end
            end
            sraq_pkg::S_STORE: begin
                if (recv_we) begin
                    n_rvalid[r_seq] = 1'b1;
                    n_adone[r_seq]  = 1'b1;
                    n_nak           = 1'b1;
                end
                n_state = (r_seq == r_exp) ? sraq_pkg::S_DLVRD : sraq_pkg::S_ATMR;
            end
            sraq_pkg::S_DLVRD: begin
                n_state = r_rvalid[r_exp] ? sraq_pkg::S_DLV : sraq_pkg::S_ATMR;
            end
            sraq_pkg::S_DLV: begin
                if (can_emit) begin
                    n_ovalid        = 1'b1;
                    n_action        = sraq_pkg::ACT_DELIVER;
                    n_oseq          = seq5(r_exp);
                    n_opay          = pay64(r_rdata);
                    n_nak           = 1'b0;
                    n_adone[r_exp]  = 1'b0;
                    n_rvalid[r_exp] = 1'b0;
                    n_exp           = inc_mod(r_exp);
                    n_state         = sraq_pkg::S_DLVRD;
                end
            end
            sraq_pkg::S_ATMR: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_action = sraq_pkg::ACT_ACK_TMR;
                    n_otmr   = r_ack_to;
                    n_state  = sraq_pkg::S_CACK;
                end
            end
            sraq_pkg::S_CACK: begin
                n_state = in_range(r_low, r_ack, r_high) ? sraq_pkg::S_CWALK : sraq_pkg::S_STAT;
            end
            sraq_pkg::S_CWALK: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_action = sraq_pkg::ACT_STOP_TMR;
                    n_oseq   = seq5(r_low);
                    if (r_cnt != '0) n_cnt = r_cnt - 1'b1;
                    n_low    = inc_mod(r_low);
                    if (r_low == r_ack) n_state = sraq_pkg::S_STAT;
                end
            end
            sraq_pkg::S_STAT: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_action = sraq_pkg::ACT_STATUS;
                    n_one    = (r_cnt < HALF_C) && r_link;
                    n_olast  = 1'b1;
                    n_state  = sraq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sraq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sraq_pkg::S_IDLE;
            r_low     <= '0;
            r_high    <= '0;
            r_exp     <= '0;
            r_cnt     <= '0;
            r_link    <= 1'b0;
            r_nak     <= 1'b0;
            r_rvalid  <= '0;
            r_adone   <= '0;
            r_ovalid  <= 1'b0;
            r_data_to <= sraq_pkg::DATA_TIMEOUT_RST;
            r_ack_to  <= sraq_pkg::ACK_TIMEOUT_RST;
        end else begin
            r_state  <= n_state;
            r_low    <= n_low;
            r_high   <= n_high;
            r_exp    <= n_exp;
            r_cnt    <= n_cnt;
            r_link   <= n_link;
            r_nak    <= n_nak;
            r_rvalid <= n_rvalid;
            r_adone  <= n_adone;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                if (i_cfg_index == sraq_pkg::CFG_DATA_TIMEOUT) r_data_to <= i_cfg_data;
                if (i_cfg_index == sraq_pkg::CFG_ACK_TIMEOUT)  r_ack_to  <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == sraq_pkg::S_IDLE) && i_in_valid) begin
            r_cmd  <= i_command;
            r_pay  <= i_payload[PAYLOAD_BITS-1:0];
            r_kind <= i_frame_kind;
            r_seq  <= wrap_in(i_frame_seq);
            r_good <= i_frame_good;
            r_tseq <= wrap_in(i_timeout_seq);
        end
        if ((r_state == sraq_pkg::S_IDLE) && i_in_valid) begin
            r_ack <= wrap_in(i_frame_ack);
        end else begin
            r_ack <= n_ack;
        end
        r_tx_seq <= n_tx_seq;
        r_action <= n_action;
        r_oseq   <= n_oseq;
        r_oack   <= n_oack;
        r_opay   <= n_opay;
        r_otmr   <= n_otmr;
        r_one    <= n_one;
        r_olast  <= n_olast;
    end

    assign o_in_ready       = (r_state == sraq_pkg::S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_action         = r_action;
    assign o_out_seq        = r_oseq;
    assign o_out_ack        = r_oack;
    assign o_out_payload    = r_opay;
    assign o_timer_value    = r_otmr;
    assign o_network_enable = r_one;
    assign o_last           = r_olast;

    `SRAQ_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= HALF_C, "outstanding count above half window")
    `SRAQ_ASSERT_IMP(a_idle_no_pending, r_state == sraq_pkg::S_IDLE, !r_rvalid[r_exp],
                     "expected slot still held while idle")
    `SRAQ_ASSERT_NEXT(a_accept_disp, i_in_valid && o_in_ready, r_state == sraq_pkg::S_DISP,
                      "accepted beat not decoded")
    `SRAQ_ASSERT_IMP(a_last_status, r_ovalid, o_last == (o_action == sraq_pkg::ACT_STATUS),
                     "last flag not on status beat")
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the selective repeat ARQ controller: directed and random events.
module testbench;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] payload;
        logic [1:0]  kind;
        logic [4:0]  fseq;
        logic [4:0]  fack;
        logic        good;
        logic [4:0]  tseq;
    } t_arq_event;

    typedef struct packed {
        logic [2:0]  act;
        logic [4:0]  seq;
        logic [4:0]  ack;
        logic [63:0] payload;
        logic [15:0] tval;
        logic        net_en;
        logic        last;
    } t_arq_action;

    class t_arq_scoreboard;
        logic [63:0] send_buf[32];
        logic [63:0] recv_buf[32];
        bit          recv_held[32];
        bit          acked[32];
        bit [4:0]    lo, hi, nxt, exp_seq;
        int unsigned pending;
        bit          link_up, nak_out;
        bit [15:0]   data_tmo, ack_tmo;
        t_arq_action actions_due[$];
        int          errors, events_seen, beats_seen, deliveries, frees, drops;

        function new();
            for (int k = 0; k < 32; k++) begin
                recv_held[k] = 0;
                acked[k] = 0;
            end
            lo = 0; hi = 0; nxt = 0; exp_seq = 0; pending = 0;
            link_up = 0; nak_out = 0;
            data_tmo = sraq_pkg::DATA_TIMEOUT_RST;
            ack_tmo = sraq_pkg::ACK_TIMEOUT_RST;
            errors = 0; events_seen = 0; beats_seen = 0;
            deliveries = 0; frees = 0; drops = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == sraq_pkg::CFG_DATA_TIMEOUT) data_tmo = val;
            else ack_tmo = val;
        endfunction

        function bit in_window(bit [4:0] base, bit [4:0] pos, bit [4:0] top);
            bit [4:0] dp, dh;
            dp = pos - base;
            dh = top - base;
            return dp < dh;
        endfunction

        function void push(logic [2:0] act, logic [4:0] seq, logic [4:0] ack,
                           logic [63:0] pay, logic [15:0] tv, logic ne, logic lst);
            t_arq_action a;
            a.act = act; a.seq = seq; a.ack = ack; a.payload = pay;
            a.tval = tv; a.net_en = ne; a.last = lst;
            actions_due.push_back(a);
        endfunction

        function void resend(bit [4:0] seq);
            push(sraq_pkg::ACT_SEND_DATA, seq, exp_seq - 5'd1, send_buf[seq], data_tmo, 0, 0);
            link_up = 0;
        endfunction

        function void nak_or_timer();
            if (!nak_out) begin
                nak_out = 1;
                push(sraq_pkg::ACT_SEND_NAK, 0, exp_seq, 0, 0, 0, 0);
                link_up = 0;
            end else begin
                push(sraq_pkg::ACT_ACK_TMR, 0, 0, 0, ack_tmo, 0, 0);
            end
        endfunction

        function void release_upto(bit [4:0] a);
            bit [4:0] s;
            if (!in_window(lo, a, hi)) return;
            do begin
                s = lo;
                push(sraq_pkg::ACT_STOP_TMR, s, 0, 0, 0, 0, 0);
                frees++;
                if (pending > 0) pending--;
                lo = lo + 5'd1;
            end while (s != a);
        endfunction

        function void note_event(t_arq_event e);
            bit [4:0] ack, i, a;
            events_seen++;
            case (e.cmd)
                sraq_pkg::CMD_NEW_PACKET: begin
                    if (pending < 16) begin
                        send_buf[hi] = e.payload;
                        pending++;
                        resend(nxt);
                        nxt = nxt + 5'd1;
                        hi = hi + 5'd1;
                    end else drops++;
                end
                sraq_pkg::CMD_LINK_READY: link_up = 1;
                sraq_pkg::CMD_FRAME: begin
                    if (!e.good) nak_or_timer();
                    else begin
                        ack = e.fack;
                        if (e.kind == sraq_pkg::KIND_NAK) begin
                            if (in_window(lo, ack, hi)) resend(ack);
                            ack = ack - 5'd1;
                        end else if (e.kind == sraq_pkg::KIND_DATA) begin
                            if (e.fseq != exp_seq) nak_or_timer();
                            if (in_window(exp_seq, e.fseq, exp_seq + 5'd16)) begin
                                recv_buf[e.fseq] = e.payload;
                                recv_held[e.fseq] = 1;
                                nak_out = 1;
                                acked[e.fseq] = 1;
                            end
                            i = e.fseq;
                            while (i == exp_seq && recv_held[i]) begin
                                push(sraq_pkg::ACT_DELIVER, i, 0, recv_buf[i], 0, 0, 0);
                                deliveries++;
                                nak_out = 0;
                                acked[i] = 0;
                                recv_held[i] = 0;
                                exp_seq = exp_seq + 5'd1;
                                i = i + 5'd1;
                            end
                            push(sraq_pkg::ACT_ACK_TMR, 0, 0, 0, ack_tmo, 0, 0);
                        end
                        release_upto(ack);
                    end
                end
                sraq_pkg::CMD_DATA_TIMEOUT: if (in_window(lo, e.tseq, hi)) resend(e.tseq);
                sraq_pkg::CMD_ACK_TIMEOUT: begin
                    a = exp_seq - 5'd1;
                    if (!acked[a]) begin
                        acked[a] = 1;
                        push(sraq_pkg::ACT_SEND_ACK, 0, a, 0, 0, 0, 0);
                        link_up = 0;
                    end
                end
                default: ;
            endcase
            push(sraq_pkg::ACT_STATUS, 0, 0, 0, 0, (pending < 16) && link_up, 1);
        endfunction

        function void check_beat(t_arq_action got);
            t_arq_action w;
            beats_seen++;
            if (actions_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat act=%0d seq=%0d ack=%0d", $time,
                         got.act, got.seq, got.ack);
                return;
            end
            w = actions_due.pop_front();
            if (got.act !== w.act) begin
                errors++;
                $display("%0t: action exp %0d got %0d", $time, w.act, got.act);
            end
            if (got.seq !== w.seq) begin
                errors++;
                $display("%0t: seq exp %0d got %0d", $time, w.seq, got.seq);
            end
            if (got.ack !== w.ack) begin
                errors++;
                $display("%0t: ack exp %0d got %0d", $time, w.ack, got.ack);
            end
            if (got.payload !== w.payload) begin
                errors++;
                $display("%0t: payload exp %h got %h", $time, w.payload, got.payload);
            end
            if (got.tval !== w.tval) begin
                errors++;
                $display("%0t: timer exp %0d got %0d", $time, w.tval, got.tval);
            end
            if (got.net_en !== w.net_en) begin
                errors++;
                $display("%0t: net enable exp %0d got %0d", $time, w.net_en, got.net_en);
            end
            if (got.last !== w.last) begin
                errors++;
                $display("%0t: last exp %0d got %0d", $time, w.last, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [2:0]  i_command = 0;
    logic [63:0] i_payload = 0;
    logic [1:0]  i_frame_kind = 0;
    logic [4:0]  i_frame_seq = 0;
    logic [4:0]  i_frame_ack = 0;
    logic        i_frame_good = 0;
    logic [4:0]  i_timeout_seq = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [2:0]  o_action;
    logic [4:0]  o_out_seq;
    logic [4:0]  o_out_ack;
    logic [63:0] o_out_payload;
    logic [15:0] o_timer_value;
    logic        o_network_enable;
    logic        o_last;
    logic        i_cfg_we = 0;
    logic        i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;

    selective_repeat_arq_controller_unit i_dut (.*);

    always #6 i_clk = ~i_clk;

    t_arq_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  stall_mode = 0;
    int  burst_left = 0;
    int  max_gap = 4;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_arq_action got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.act = o_action; got.seq = o_out_seq; got.ack = o_out_ack;
            got.payload = o_out_payload; got.tval = o_timer_value;
            got.net_en = o_network_enable; got.last = o_last;
            sb.check_beat(got);
        end
        if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 300;
            i_out_ready <= 0;
        end else if (stall_mode == 0) i_out_ready <= 1;
        else if (stall_mode == 1) i_out_ready <= 1'($urandom_range(0, 1));
        else i_out_ready <= ($urandom_range(0, 3) == 0);
    end

    task automatic drive_event(t_arq_event e);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_in_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1;
        i_command <= e.cmd; i_payload <= e.payload; i_frame_kind <= e.kind;
        i_frame_seq <= e.fseq; i_frame_ack <= e.fack; i_frame_good <= e.good;
        i_timeout_seq <= e.tseq;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_event(e);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.actions_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] dto, logic [15:0] ato);
        i_cfg_we <= 1; i_cfg_index <= sraq_pkg::CFG_DATA_TIMEOUT; i_cfg_data <= dto;
        @(posedge i_clk);
        sb.set_reg(sraq_pkg::CFG_DATA_TIMEOUT, dto);
        i_cfg_index <= sraq_pkg::CFG_ACK_TIMEOUT; i_cfg_data <= ato;
        @(posedge i_clk);
        sb.set_reg(sraq_pkg::CFG_ACK_TIMEOUT, ato);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_arq_event mk(logic [2:0] c, logic [63:0] p, logic [1:0] k,
                                      logic [4:0] s, logic [4:0] a, logic g, logic [4:0] t);
        t_arq_event e;
        e.cmd = c; e.payload = p; e.kind = k; e.fseq = s; e.fack = a; e.good = g;
        e.tseq = t;
        return e;
    endfunction

    function automatic t_arq_event random_event(int np);
        t_arq_event e;
        int r;
        e = mk(3'($urandom_range(0, 7)), {$urandom, $urandom}, 2'($urandom_range(0, 3)),
               5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
               1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
        r = $urandom_range(0, 99);
        if (r < np) e.cmd = sraq_pkg::CMD_NEW_PACKET;
        else if (r < np + 10) e.cmd = sraq_pkg::CMD_LINK_READY;
        else if (r < np + 55) begin
            e.cmd = sraq_pkg::CMD_FRAME;
            r = $urandom_range(0, 99);
            e.kind = (r < 50) ? sraq_pkg::KIND_DATA : (r < 80) ? sraq_pkg::KIND_ACK :
                     (r < 95) ? sraq_pkg::KIND_NAK : 2'd3;
            e.good = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 4) != 0) begin
                e.fseq = sb.exp_seq + 5'($urandom_range(0, 4));
                e.fack = sb.lo + 5'($urandom_range(0, sb.pending));
            end
        end else if (r < np + 65) begin
            e.cmd = sraq_pkg::CMD_DATA_TIMEOUT;
            if ($urandom_range(0, 4) != 0) e.tseq = sb.lo + 5'($urandom_range(0, sb.pending));
        end else if (r < np + 78) e.cmd = sraq_pkg::CMD_ACK_TIMEOUT;
        return e;
    endfunction

    initial begin
        t_arq_event dir[$];
        int np[4] = '{30, 55, 15, 35};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        dir.push_back(mk(sraq_pkg::CMD_LINK_READY, 0, 0, 0, 0, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_NEW_PACKET, '1, 0, 0, 0, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_NEW_PACKET, '0, 0, 0, 0, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_DATA_TIMEOUT, 0, 0, 0, 0, 1, 5'd1));
        dir.push_back(mk(sraq_pkg::CMD_DATA_TIMEOUT, 0, 0, 0, 0, 1, 5'd20));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, 0, sraq_pkg::KIND_NAK, 0, 5'd0, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, 0, sraq_pkg::KIND_NAK, 0, 5'd9, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, 0, sraq_pkg::KIND_ACK, 0, 5'd0, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, 0, 2'd3, 0, 5'd1, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, {$urandom, $urandom}, sraq_pkg::KIND_DATA,
                         5'd0, 5'd31, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, '1, sraq_pkg::KIND_DATA, 5'd2, 5'd31, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, {$urandom, $urandom}, sraq_pkg::KIND_DATA,
                         5'd3, 5'd31, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, {$urandom, $urandom}, sraq_pkg::KIND_DATA,
                         5'd1, 5'd31, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, 0, sraq_pkg::KIND_DATA, 5'd4, 5'd0, 0, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, 0, sraq_pkg::KIND_NAK, 5'd4, 5'd0, 0, 0));
        dir.push_back(mk(sraq_pkg::CMD_FRAME, '1, sraq_pkg::KIND_DATA, 5'd20, 5'd31, 1,
                         5'd31));
        dir.push_back(mk(sraq_pkg::CMD_ACK_TIMEOUT, 0, 0, 0, 0, 1, 0));
        dir.push_back(mk(sraq_pkg::CMD_ACK_TIMEOUT, 0, 0, 0, 0, 1, 0));
        dir.push_back(mk(3'd7, '1, 2'd3, 5'd31, 5'd31, 1, 5'd31));
        dir.push_back(mk(3'd5, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(sraq_pkg::CMD_LINK_READY, 0, 0, 0, 0, 1, 0));
        foreach (dir[k]) drive_event(dir[k]);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                1: write_regs(16'd0, 16'hFFFF);
                2: write_regs(16'hFFFF, 16'd0);
                3: write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                default: ;
            endcase
            max_gap = (ph == 2) ? 0 : 6;
            if (ph == 1) hold_req = 1;
            for (int n = 0; n < 120; n++) drive_event(random_event(np[ph]));
        end

        drain();
        $display("Covered %0d events, %0d beats, %0d deliveries, %0d freed slots,",
                 sb.events_seen, sb.beats_seen, sb.deliveries, sb.frees);
        $display("%0d dropped packets over four timeout settings.", sb.drops);
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
